// File: hdl/refcounted_page_frame_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame allocator
// Shorthand for clocked properties that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rpfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Command and result beat types, operation, status and register codes.
// ----------------------------------------------------------------------------
package rpfa_pkg;

    localparam int unsigned FRAME_W = 10;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned LIMIT_W = 11;
    localparam int unsigned ENTRY_W = 11;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [1:0] OP_INIT    = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_SHARE   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_RESERVED  = 3'd3;
    localparam logic [2:0] ST_NOT_USED  = 3'd4;
    localparam logic [2:0] ST_SATURATED = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 1'd1;

    localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 11'd1024;
    localparam logic [LIMIT_W-1:0] RESERVED_RESET    = 11'd256;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FRAME_W-1:0] frame;
    } t_cmd;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_out;
        logic [2:0]         status;
        logic [COUNT_W-1:0] count_after;
        logic [LIMIT_W-1:0] free_frames;
    } t_result;

endpackage

// File: hdl/refcounted_page_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// Reference-counted page frame allocator
// Allocate, release and add-reference raise the result strobe after S_ALLOC or
// S_RMW (read the stack or count memory, then modify and write back); busy is
// low again in the strobe cycle, so a new command can start in that cycle.
// Allocate on an empty list and out-of-range frames answer in the next cycle.
// Init sweeps every frame and then answers; after reset the same sweep clears
// the counts with busy. Results are never held.
// ----------------------------------------------------------------------------
`include "refcounted_page_frame_allocator_unit_macros.svh"

module refcounted_page_frame_allocator_unit #(
    parameter int unsigned NUM_FRAMES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  rpfa_pkg::t_cmd                   i_cmd,
    output logic                             o_strobe,
    output rpfa_pkg::t_result                o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rpfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rpfa_pkg::LIMIT_W-1:0]     i_cfg_data
);

    localparam int unsigned AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int unsigned DW = $clog2(NUM_FRAMES + 1);
    localparam int unsigned MW = ((AW > rpfa_pkg::LIMIT_W) ? AW : rpfa_pkg::LIMIT_W) + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_ALLOC,
        S_RMW
    } t_state;

    t_state                         r_state;
    logic [AW-1:0]                  r_idx;
    logic [DW-1:0]                  r_depth;
    logic [1:0]                     r_op;
    logic [rpfa_pkg::FRAME_W-1:0]   r_frame;
    logic                           r_strobe;
    rpfa_pkg::t_result              r_result;
    logic [rpfa_pkg::LIMIT_W-1:0]   r_frame_limit;
    logic [rpfa_pkg::LIMIT_W-1:0]   r_reserved;

    logic [rpfa_pkg::COUNT_W-1:0]   r_count_mem [NUM_FRAMES];
    logic [rpfa_pkg::ENTRY_W-1:0]   r_stack_mem [NUM_FRAMES];
    logic [rpfa_pkg::COUNT_W-1:0]   r_count_rd;
    logic [rpfa_pkg::ENTRY_W-1:0]   r_stack_rd;

    logic                           cnt_we;
    logic [AW-1:0]                  cnt_wa;
    logic [rpfa_pkg::COUNT_W-1:0]   cnt_wd;
    logic [AW-1:0]                  cnt_ra;
    logic                           stk_we;
    logic [AW-1:0]                  stk_wa;
    logic [rpfa_pkg::ENTRY_W-1:0]   stk_wd;
    logic [AW-1:0]                  stk_ra;

    logic [MW-1:0]                  end_of_mem;
    logic                           in_range;
    logic                           sweep_push;
    logic                           sweep_last;
    logic                           alloc_valid;
    logic                           stack_room;
    logic [2:0]                     rmw_status;
    logic [rpfa_pkg::COUNT_W-1:0]   rmw_count;
    logic                           rmw_write;
    logic                           rmw_push;
    logic [DW-1:0]                  n_depth;

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= rpfa_pkg::FRAME_LIMIT_RESET;
            r_reserved    <= rpfa_pkg::RESERVED_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rpfa_pkg::CFG_FRAME_LIMIT: r_frame_limit <= i_cfg_data;
                rpfa_pkg::CFG_RESERVED:    r_reserved    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        end_of_mem = (MW'(r_frame_limit) < MW'(NUM_FRAMES)) ? MW'(r_frame_limit)
                                                            : MW'(NUM_FRAMES);
        in_range    = MW'(i_cmd.frame) < end_of_mem;
        stack_room  = r_depth < DW'(NUM_FRAMES);
        sweep_last  = r_idx == AW'(NUM_FRAMES - 1);
        sweep_push  = (r_state == S_INIT) && (MW'(r_idx) >= MW'(r_reserved))
                      && (MW'(r_idx) < end_of_mem) && stack_room;
        alloc_valid = MW'(r_stack_rd) < MW'(NUM_FRAMES);

        // Status checks on the count that has just been read back.
        rmw_status = rpfa_pkg::ST_OK;
        rmw_count  = r_count_rd;
        rmw_write  = 1'b0;
        rmw_push   = 1'b0;
        if (MW'(r_frame) < MW'(r_reserved)) begin
            rmw_status = rpfa_pkg::ST_RESERVED;
        end else if (r_count_rd == '0) begin
            rmw_status = rpfa_pkg::ST_NOT_USED;
        end else if (r_op == rpfa_pkg::OP_RELEASE) begin
            rmw_count = r_count_rd - 1'b1;
            rmw_write = 1'b1;
            rmw_push  = (rmw_count == '0) && stack_room;
        end else if (r_count_rd == rpfa_pkg::COUNT_MAX) begin
            rmw_status = rpfa_pkg::ST_SATURATED;
        end else begin
            rmw_count = r_count_rd + 1'b1;
            rmw_write = 1'b1;
        end

        cnt_ra = AW'(i_cmd.frame);
        stk_ra = AW'(r_depth - 1'b1);
        cnt_we = 1'b0;
        cnt_wa = r_idx;
        cnt_wd = '0;
        stk_we = 1'b0;
        stk_wa = AW'(r_depth);
        stk_wd = rpfa_pkg::ENTRY_W'(r_idx);
        n_depth = r_depth;
        case (r_state)
            S_CLEAR: begin
                cnt_we = 1'b1;
            end
            S_INIT: begin
                cnt_we = 1'b1;
                stk_we = sweep_push;
                if (sweep_push) begin
                    n_depth = r_depth + 1'b1;
                end
            end
            S_ALLOC: begin
                cnt_we = alloc_valid;
                cnt_wa = AW'(r_stack_rd);
                cnt_wd = rpfa_pkg::COUNT_W'(1);
            end
            S_RMW: begin
                cnt_we = rmw_write;
                cnt_wa = AW'(r_frame);
                cnt_wd = rmw_count;
                stk_we = rmw_push;
                stk_wd = rpfa_pkg::ENTRY_W'(r_frame);
                if (rmw_push) begin
                    n_depth = r_depth + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_count_mem[cnt_wa] <= cnt_wd;
        end
        r_count_rd <= r_count_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack_mem[stk_wa] <= stk_wd;
        end
        r_stack_rd <= r_stack_mem[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_depth  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (sweep_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_cmd.opcode;
                        r_frame <= i_cmd.frame;
                        case (i_cmd.opcode)
                            rpfa_pkg::OP_INIT: begin
                                r_state <= S_INIT;
                                r_idx   <= '0;
                                r_depth <= '0;
                            end
                            rpfa_pkg::OP_ALLOC: begin
                                if (r_depth == '0) begin
                                    r_strobe             <= 1'b1;
                                    r_result.frame_out   <= '0;
                                    r_result.status      <= rpfa_pkg::ST_EMPTY;
                                    r_result.count_after <= '0;
                                    r_result.free_frames <= '0;
                                end else begin
                                    r_depth <= r_depth - 1'b1;
                                    r_state <= S_ALLOC;
                                end
                            end
                            default: begin
                                if (in_range) begin
                                    r_state <= S_RMW;
                                end else begin
                                    r_strobe             <= 1'b1;
                                    r_result.frame_out   <= i_cmd.frame;
                                    r_result.status      <= rpfa_pkg::ST_RANGE;
                                    r_result.count_after <= '0;
                                    r_result.free_frames <= rpfa_pkg::LIMIT_W'(r_depth);
                                end
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    r_idx   <= r_idx + 1'b1;
                    r_depth <= n_depth;
                    if (sweep_last) begin
                        r_state              <= S_IDLE;
                        r_strobe             <= 1'b1;
                        r_result.frame_out   <= r_frame;
                        r_result.status      <= rpfa_pkg::ST_OK;
                        r_result.count_after <= '0;
                        r_result.free_frames <= rpfa_pkg::LIMIT_W'(n_depth);
                    end
                end
                S_ALLOC: begin
                    r_state              <= S_IDLE;
                    r_strobe             <= 1'b1;
                    r_result.frame_out   <= rpfa_pkg::FRAME_W'(r_stack_rd);
                    r_result.status      <= rpfa_pkg::ST_OK;
                    r_result.count_after <= rpfa_pkg::COUNT_W'(1);
                    r_result.free_frames <= rpfa_pkg::LIMIT_W'(r_depth);
                end
                S_RMW: begin
                    r_state              <= S_IDLE;
                    r_depth              <= n_depth;
                    r_strobe             <= 1'b1;
                    r_result.frame_out   <= r_frame;
                    r_result.status      <= rmw_status;
                    r_result.count_after <= rmw_count;
                    r_result.free_frames <= rpfa_pkg::LIMIT_W'(n_depth);
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A read-modify-write always ends in exactly one result beat.
    `RPFA_ASSERT_NEXT(a_rmw_result, r_state == S_RMW || r_state == S_ALLOC,
        o_strobe, "missing result beat after read-modify-write")
    `RPFA_ASSERT_NEXT(a_alloc_count, r_state == S_ALLOC,
        o_result.count_after == 16'd1 && o_result.status == rpfa_pkg::ST_OK,
        "allocate did not report a count of one")
    `RPFA_ASSERT_SAME(a_depth_bound, 1'b1, r_depth <= DW'(NUM_FRAMES),
        "free list depth beyond capacity")
    `RPFA_ASSERT_SAME(a_clear_quiet, r_state == S_CLEAR, !o_strobe && r_depth == '0,
        "activity during the clearing sweep")

endmodule
